[rtl/imh_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg: shared types and codes for the indexed min-heap
// Command and status codes, engine state type and the queue entry format.
// ----------------------------------------------------------------------------
package imh_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_POP    = 2'd1;
  localparam logic [1:0] CMD_DEC    = 2'd2;
  localparam logic [1:0] CMD_NOP    = 2'd3;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_DUP    = 3'd2;
  localparam logic [2:0] ST_EMPTY  = 3'd3;
  localparam logic [2:0] ST_ABSENT = 3'd4;
  localparam logic [2:0] ST_ZERO   = 3'd5;

  localparam int KEY_W   = 10;
  localparam int VALIN_W = 16;
  localparam int CNT_W   = 11;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE,
    S_INS_P, S_INS_W,
    S_POP_R, S_POP_L, S_POP_W,
    S_DEC_R, S_DEC_W, S_DEC_CHK,
    S_UP_RD, S_UP_WT, S_UP_CMP,
    S_DN_RL, S_DN_RR, S_DN_WT, S_DN_CMP,
    S_DONE
  } imh_state_t;

  typedef struct packed {
    logic [1:0]         command;
    logic [KEY_W-1:0]   key;
    logic [VALIN_W-1:0] value;
  } imh_cmd_t;

endpackage

[rtl/imh_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_ram: generic single-port RAM
// One write or one read per cycle; read data registered.
// ----------------------------------------------------------------------------
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[rtl/imh_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_queue: front end command queue
// Two-entry queue that takes command transfers and hands them to the engine.
// ----------------------------------------------------------------------------
module imh_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  imh_pkg::imh_cmd_t in_cmd,
  output logic              q_valid,
  input  logic              q_ready,
  output imh_pkg::imh_cmd_t q_cmd
);
  imh_pkg::imh_cmd_t buf_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = buf_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= in_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop from empty queue");
endmodule

[rtl/imh_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_engine: heap engine
// Executes one command at a time on the slot and position memories.
// ----------------------------------------------------------------------------
module imh_engine #(
  parameter int NUM_KEYS    = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  imh_pkg::imh_cmd_t           q_cmd,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [imh_pkg::KEY_W-1:0]   out_min_key,
  output logic [imh_pkg::VALIN_W-1:0] out_min_value,
  output logic [imh_pkg::CNT_W-1:0]   out_entry_count,
  output logic                        out_is_empty,
  output logic [2:0]                  out_status
);
  localparam int AW = $clog2(NUM_KEYS);
  localparam int SW = AW + 1;
  localparam int VW = VALUE_WIDTH;
  localparam int KW = imh_pkg::KEY_W;
  localparam int HW = KW + VW;
  localparam int PW = AW + 1;
  localparam logic [SW-1:0] FULL_N = SW'(NUM_KEYS);

  imh_pkg::imh_state_t st_r, st_nxt;

  logic          h_we;
  logic [AW-1:0] h_addr;
  logic [HW-1:0] h_wd, h_rd;
  logic          p_we;
  logic [AW-1:0] p_addr;
  logic [PW-1:0] p_wd, p_rd;

  imh_ram #(.WIDTH(HW), .DEPTH(NUM_KEYS)) u_heap (
    .clk(clk), .we(h_we), .addr(h_addr), .wdata(h_wd), .rdata(h_rd));
  imh_ram #(.WIDTH(PW), .DEPTH(NUM_KEYS)) u_pos (
    .clk(clk), .we(p_we), .addr(p_addr), .wdata(p_wd), .rdata(p_rd));

  logic [SW-1:0] size_r, size_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] oth_r, oth_nxt;
  logic [KW-1:0] ck_r, ck_nxt, ok_r, ok_nxt, lk_r, lk_nxt;
  logic [VW-1:0] cv_r, cv_nxt, ov_r, ov_nxt, lv_r, lv_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [2:0]    sts_r, sts_nxt;
  logic          ov_valid_r, ov_valid_nxt;
  logic [KW-1:0] ok_out_r, ok_out_nxt;
  logic [VW-1:0] ov_out_r, ov_out_nxt;
  logic [SW-1:0] cnt_out_r, cnt_out_nxt;
  logic [2:0]    so_r, so_nxt;
  logic          key_ok;
  logic [SW-1:0] lch;
  logic [KW-1:0] rk;
  logic [VW-1:0] rv;

  assign rk = h_rd[HW-1:VW];
  assign rv = h_rd[VW-1:0];
  assign key_ok = ({1'b0, q_cmd.key} < (KW+1)'(NUM_KEYS)) || (NUM_KEYS > (1 << KW));
  assign lch = {idx_r, 1'b1};

  assign out_valid       = ov_valid_r;
  assign out_min_key     = ok_out_r;
  assign out_min_value   = imh_pkg::VALIN_W'(ov_out_r);
  assign out_entry_count = imh_pkg::CNT_W'(cnt_out_r);
  assign out_is_empty    = (cnt_out_r == '0);
  assign out_status      = so_r;

  always_comb begin
    st_nxt = st_r; size_nxt = size_r; clr_nxt = clr_r; idx_nxt = idx_r;
    oth_nxt = oth_r; ck_nxt = ck_r; cv_nxt = cv_r; ok_nxt = ok_r; ov_nxt = ov_r;
    lk_nxt = lk_r; lv_nxt = lv_r; ph_nxt = ph_r; sts_nxt = sts_r;
    ov_valid_nxt = ov_valid_r; ok_out_nxt = ok_out_r; ov_out_nxt = ov_out_r;
    cnt_out_nxt = cnt_out_r; so_nxt = so_r;
    h_we = 1'b0; h_addr = idx_r; h_wd = {ck_r, cv_r};
    p_we = 1'b0; p_addr = ck_r; p_wd = {1'b1, idx_r};
    q_ready = 1'b0;
    if (out_valid && out_ready) ov_valid_nxt = 1'b0;
    unique case (st_r)
      imh_pkg::S_CLEAR: begin
        p_we = 1'b1; p_addr = clr_r; p_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(NUM_KEYS - 1)) st_nxt = imh_pkg::S_IDLE;
      end
      imh_pkg::S_IDLE: begin
        q_ready = 1'b1;
        p_addr = AW'(q_cmd.key);
        h_addr = '0;
        sts_nxt = imh_pkg::ST_OK;
        ck_nxt = q_cmd.key; cv_nxt = VW'(q_cmd.value);
        if (q_valid) begin
          priority case (q_cmd.command)
            imh_pkg::CMD_INSERT: begin
              if (!key_ok) begin
                sts_nxt = imh_pkg::ST_ABSENT; st_nxt = imh_pkg::S_DONE;
              end else if (size_r >= FULL_N) begin
                sts_nxt = imh_pkg::ST_FULL; st_nxt = imh_pkg::S_DONE;
              end else st_nxt = imh_pkg::S_INS_P;
            end
            imh_pkg::CMD_POP: begin
              if (size_r == '0) begin
                sts_nxt = imh_pkg::ST_EMPTY; st_nxt = imh_pkg::S_DONE;
              end else st_nxt = imh_pkg::S_POP_R;
            end
            imh_pkg::CMD_DEC: begin
              if (!key_ok) begin
                sts_nxt = imh_pkg::ST_ABSENT; st_nxt = imh_pkg::S_DONE;
              end else st_nxt = imh_pkg::S_DEC_R;
            end
            default: st_nxt = imh_pkg::S_DONE;
          endcase
        end
      end
      imh_pkg::S_INS_P: begin
        if (p_rd[PW-1]) begin
          sts_nxt = imh_pkg::ST_DUP; st_nxt = imh_pkg::S_DONE;
        end else begin
          idx_nxt = AW'(size_r);
          size_nxt = size_r + 1'b1;
          st_nxt = imh_pkg::S_INS_W;
        end
      end
      imh_pkg::S_INS_W: begin
        h_we = 1'b1; p_we = 1'b1;
        st_nxt = imh_pkg::S_UP_RD;
      end
      imh_pkg::S_POP_R: begin
        // h_rd holds the top slot; fetch the last slot next
        p_addr = rk; p_we = 1'b1; p_wd = '0;
        h_addr = AW'(size_r - 1'b1);
        size_nxt = size_r - 1'b1;
        st_nxt = imh_pkg::S_POP_L;
      end
      imh_pkg::S_POP_L: begin
        ck_nxt = rk; cv_nxt = rv; idx_nxt = '0;
        if (size_r == '0) st_nxt = imh_pkg::S_DONE;
        else st_nxt = imh_pkg::S_POP_W;
      end
      imh_pkg::S_POP_W: begin
        h_we = 1'b1; p_we = 1'b1;
        st_nxt = imh_pkg::S_DN_RL;
      end
      imh_pkg::S_DEC_R: begin
        if (!p_rd[PW-1] || ({1'b0, p_rd[AW-1:0]} >= size_r)) begin
          sts_nxt = imh_pkg::ST_ABSENT; st_nxt = imh_pkg::S_DONE;
        end else begin
          idx_nxt = p_rd[AW-1:0];
          h_addr = p_rd[AW-1:0];
          st_nxt = imh_pkg::S_DEC_W;
        end
      end
      imh_pkg::S_DEC_W: st_nxt = imh_pkg::S_DEC_CHK;
      imh_pkg::S_DEC_CHK: begin
        if (rv == '0) begin
          sts_nxt = imh_pkg::ST_ZERO; st_nxt = imh_pkg::S_DONE;
        end else begin
          cv_nxt = rv - 1'b1; ck_nxt = rk;
          h_we = 1'b1; h_wd = {rk, rv - 1'b1};
          st_nxt = imh_pkg::S_UP_RD;
        end
      end
      // sift up: the moving entry (ck, cv) sits at idx
      imh_pkg::S_UP_RD: begin
        if (idx_r == '0) st_nxt = imh_pkg::S_DONE;
        else begin
          oth_nxt = (idx_r - 1'b1) >> 1;
          h_addr = (idx_r - 1'b1) >> 1;
          st_nxt = imh_pkg::S_UP_WT;
        end
      end
      imh_pkg::S_UP_WT: begin
        h_addr = oth_r;
        st_nxt = imh_pkg::S_UP_CMP;
        ph_nxt = 2'd0;
      end
      imh_pkg::S_UP_CMP: begin
        if (ph_r == 2'd0) begin
          if (!(cv_r < rv)) st_nxt = imh_pkg::S_DONE;
          else begin
            ok_nxt = rk; ov_nxt = rv;
            h_we = 1'b1; h_addr = idx_r; h_wd = {rk, rv};
            p_we = 1'b1; p_addr = rk; p_wd = {1'b1, idx_r};
            ph_nxt = 2'd1;
          end
        end else begin
          h_we = 1'b1; h_addr = oth_r;
          p_we = 1'b1; p_addr = ck_r; p_wd = {1'b1, oth_r};
          idx_nxt = oth_r;
          st_nxt = imh_pkg::S_UP_RD;
        end
      end
      // sift down: read left then right child
      imh_pkg::S_DN_RL: begin
        if ({1'b0, lch} >= {1'b0, size_r}) st_nxt = imh_pkg::S_DONE;
        else begin
          h_addr = AW'(lch);
          st_nxt = imh_pkg::S_DN_RR;
        end
      end
      imh_pkg::S_DN_RR: begin
        // h_rd holds the left child here
        lk_nxt = rk; lv_nxt = rv;
        h_addr = AW'(lch + 1'b1);
        st_nxt = imh_pkg::S_DN_WT;
      end
      imh_pkg::S_DN_WT: begin
        // h_rd holds the right child here; keep it on the read port
        h_addr = AW'(lch + 1'b1);
        st_nxt = imh_pkg::S_DN_CMP;
        ph_nxt = 2'd0;
      end
      imh_pkg::S_DN_CMP: begin
        if (ph_r == 2'd0) begin
          if (({1'b0, lch} + 1'b1 < {1'b0, size_r}) && (rv < lv_r)) begin
            ok_nxt = rk; ov_nxt = rv; oth_nxt = AW'(lch + 1'b1);
          end else begin
            ok_nxt = lk_r; ov_nxt = lv_r; oth_nxt = AW'(lch);
          end
          ph_nxt = 2'd1;
        end else if (!(ov_r < cv_r)) begin
          st_nxt = imh_pkg::S_DONE;
        end else if (ph_r == 2'd1) begin
          h_we = 1'b1; h_addr = idx_r; h_wd = {ok_r, ov_r};
          p_we = 1'b1; p_addr = ok_r; p_wd = {1'b1, idx_r};
          ph_nxt = 2'd2;
        end else begin
          h_we = 1'b1; h_addr = oth_r;
          p_we = 1'b1; p_addr = ck_r; p_wd = {1'b1, oth_r};
          idx_nxt = oth_r;
          st_nxt = imh_pkg::S_DN_RL;
        end
      end
      imh_pkg::S_DONE: begin
        h_addr = '0;
        if (ph_r != 2'd3) ph_nxt = 2'd3;
        else if (!ov_valid_r || out_ready) begin
          ov_valid_nxt = 1'b1;
          ok_out_nxt = (size_r == '0) ? '0 : rk;
          ov_out_nxt = (size_r == '0) ? '0 : rv;
          cnt_out_nxt = size_r;
          so_nxt = sts_r;
          ph_nxt = 2'd0;
          st_nxt = imh_pkg::S_IDLE;
        end
      end
      default: st_nxt = imh_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; oth_r <= oth_nxt; ck_r <= ck_nxt; cv_r <= cv_nxt;
    ok_r <= ok_nxt; ov_r <= ov_nxt; lk_r <= lk_nxt; lv_r <= lv_nxt;
    sts_r <= sts_nxt;
    ok_out_r <= ok_out_nxt; ov_out_r <= ov_out_nxt; cnt_out_r <= cnt_out_nxt;
    so_r <= so_nxt;
    if (!rst_n) begin
      st_r <= imh_pkg::S_CLEAR; size_r <= '0; clr_r <= '0;
      ph_r <= 2'd0; ov_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt; size_r <= size_nxt; clr_r <= clr_nxt;
      ph_r <= ph_nxt; ov_valid_r <= ov_valid_nxt;
    end
  end

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    size_r <= FULL_N) else $error("heap size beyond capacity");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> st_r == imh_pkg::S_IDLE) else $error("command taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
endmodule

[rtl/indexed_min_heap_decrement_key.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_decrement_key: indexed binary min-heap
// Insert, pop-minimum and decrement-key on (key, value) pairs.
// ----------------------------------------------------------------------------
// After reset the block clears every entry of its NUM_KEYS-entry position
// map and takes no command transfer into the engine until that is done. A
// command is then handled one at a time: insert and decrement sift the
// entry up level by level, pop sifts the moved last entry down. The limit is
// the single port of the slot memory: each step up needs a read and two
// writes, each step down two reads and two writes.
// A two-entry queue in front takes commands while the engine is busy, and
// the result register holds one result while the next command runs. Every
// command yields exactly one result transfer carrying the new minimum, the
// count and a status code; a flagged command leaves the heap untouched.
module indexed_min_heap_decrement_key #(
  parameter int NUM_KEYS    = 1024,
  parameter int VALUE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [9:0]  in_key,
  input  logic [15:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_min_key,
  output logic [15:0] out_min_value,
  output logic [10:0] out_entry_count,
  output logic        out_is_empty,
  output logic [2:0]  out_status
);
  imh_pkg::imh_cmd_t in_cmd, q_cmd;
  logic q_valid, q_ready;

  // The value is narrowed to VALUE_WIDTH bits inside the engine.
  assign in_cmd.command = in_command;
  assign in_cmd.key     = in_key;
  assign in_cmd.value   = in_value;

  imh_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd));

  imh_engine #(.NUM_KEYS(NUM_KEYS), .VALUE_WIDTH(VALUE_WIDTH)) u_engine (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_min_key(out_min_key), .out_min_value(out_min_value),
    .out_entry_count(out_entry_count), .out_is_empty(out_is_empty),
    .out_status(out_status));
endmodule
